### rtl/mpd_pkg.sv
// Shared types, codes and helpers for the mesh packet deframer.
`timescale 1ns / 1ps
package mpd_pkg;

	typedef enum logic [4:0] {
		SEC_HDR  = 5'b00001,
		SEC_XPT  = 5'b00010,
		SEC_PLEN = 5'b00100,
		SEC_PATH = 5'b01000,
		SEC_PAY  = 5'b10000
	} sec_t;

	localparam logic [2:0] SEC_CODE_HDR  = 3'd0;
	localparam logic [2:0] SEC_CODE_XPT  = 3'd1;
	localparam logic [2:0] SEC_CODE_PLEN = 3'd2;
	localparam logic [2:0] SEC_CODE_PATH = 3'd3;
	localparam logic [2:0] SEC_CODE_PAY  = 3'd4;

	localparam logic [1:0] END_NONE  = 2'd0;
	localparam logic [1:0] END_DONE  = 2'd1;
	localparam logic [1:0] END_TRUNC = 2'd2;

	localparam logic [3:0] MASK_RESET   = 4'd9;
	localparam logic [7:0] HDR_NO_RETX  = 8'hFF;
	localparam logic       REG_ROUTE_MASK = 1'b0;

	typedef struct packed {
		logic [2:0] section;
		logic [7:0] byte_value;
		logic [7:0] offset_in_section;
		logic [1:0] route_code;
		logic [3:0] pay_kind;
		logic [1:0] version;
		logic       no_retransmit;
		logic [2:0] hash_len;
		logic [5:0] hop_count;
		logic [7:0] path_byte_count;
		logic [7:0] payload_length;
		logic [1:0] end_status;
	} res_t;

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

### rtl/mpd_cfg.sv
// APB register file holding the transport route mask.
`timescale 1ns / 1ps
module mpd_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [3:0]  route_mask
);

	logic [3:0] mask_q;
	logic       hit;

	assign pready     = 1'b1;
	assign hit        = (paddr[2] == mpd_pkg::REG_ROUTE_MASK);
	assign route_mask = mask_q;
	assign prdata     = hit ? {28'd0, mask_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= mpd_pkg::MASK_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			mask_q <= pwdata[3:0];
		end
	end

endmodule

### rtl/mpd_parse.sv
// Section tracker: decodes one byte, latches header and path fields.
`timescale 1ns / 1ps
module mpd_parse #(
	parameter int MAX_PATH_BYTES       = 64,
	parameter int TRANSPORT_CODE_BYTES = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic [7:0]     data_byte,
	input  logic           last_byte,
	input  logic [3:0]     route_mask,
	output mpd_pkg::res_t  res
);

	mpd_pkg::sec_t sec_q, sec_nxt, sec_upd;
	logic [7:0] cnt_q, cnt_upd;
	logic [1:0] rt_q, rt_nxt;
	logic [3:0] pt_q, pt_nxt;
	logic [1:0] ver_q, ver_nxt;
	logic       nr_q, nr_nxt;
	logic [2:0] hs_q, hs_nxt;
	logic [5:0] hops_q, hops_nxt;
	logic [7:0] pb_q, pb_nxt;
	logic [7:0] pc_q, pc_nxt;
	logic [2:0] code;
	logic [7:0] offset;
	logic [8:0] cnt_p1;
	logic [8:0] prod;
	logic       is_ff;

	assign cnt_p1 = {1'b0, cnt_q} + 9'd1;
	assign is_ff  = (data_byte == mpd_pkg::HDR_NO_RETX);
	assign prod   = 9'({1'b0, data_byte[7:6]} + 3'd1) * 9'(data_byte[5:0]);

	always_comb begin
		rt_nxt   = rt_q;
		pt_nxt   = pt_q;
		ver_nxt  = ver_q;
		nr_nxt   = nr_q;
		hs_nxt   = hs_q;
		hops_nxt = hops_q;
		pb_nxt   = pb_q;
		pc_nxt   = pc_q;
		offset   = cnt_q;
		case (sec_q)
			mpd_pkg::SEC_XPT: begin
				code    = mpd_pkg::SEC_CODE_XPT;
				sec_nxt = (cnt_p1 >= 9'(TRANSPORT_CODE_BYTES)) ? mpd_pkg::SEC_PLEN
					: mpd_pkg::SEC_XPT;
			end
			mpd_pkg::SEC_PLEN: begin
				code     = mpd_pkg::SEC_CODE_PLEN;
				hs_nxt   = {1'b0, data_byte[7:6]} + 3'd1;
				hops_nxt = data_byte[5:0];
				pb_nxt   = (prod > 9'(MAX_PATH_BYTES)) ? 8'(MAX_PATH_BYTES) : prod[7:0];
				sec_nxt  = (pb_nxt == 8'd0) ? mpd_pkg::SEC_PAY : mpd_pkg::SEC_PATH;
			end
			mpd_pkg::SEC_PATH: begin
				code    = mpd_pkg::SEC_CODE_PATH;
				sec_nxt = (cnt_p1 >= {1'b0, pb_q}) ? mpd_pkg::SEC_PAY : mpd_pkg::SEC_PATH;
			end
			mpd_pkg::SEC_PAY: begin
				code    = mpd_pkg::SEC_CODE_PAY;
				pc_nxt  = mpd_pkg::sat_inc(pc_q);
				sec_nxt = mpd_pkg::SEC_PAY;
			end
			default: begin
				code     = mpd_pkg::SEC_CODE_HDR;
				offset   = 8'd0;
				nr_nxt   = is_ff;
				rt_nxt   = is_ff ? 2'd0 : data_byte[1:0];
				pt_nxt   = is_ff ? 4'd0 : data_byte[5:2];
				ver_nxt  = is_ff ? 2'd0 : data_byte[7:6];
				hs_nxt   = 3'd1;
				hops_nxt = 6'd0;
				pb_nxt   = 8'd0;
				pc_nxt   = 8'd0;
				sec_nxt  = route_mask[rt_nxt] ? mpd_pkg::SEC_XPT : mpd_pkg::SEC_PLEN;
			end
		endcase
	end

	always_comb begin
		if (last_byte) begin
			sec_upd = mpd_pkg::SEC_HDR;
			cnt_upd = 8'd0;
		end else if (sec_nxt != sec_q) begin
			sec_upd = sec_nxt;
			cnt_upd = 8'd0;
		end else begin
			sec_upd = sec_nxt;
			cnt_upd = mpd_pkg::sat_inc(cnt_q);
		end
	end

	always_comb begin
		res.section           = code;
		res.byte_value        = data_byte;
		res.offset_in_section = offset;
		res.route_code        = rt_nxt;
		res.pay_kind          = pt_nxt;
		res.version           = ver_nxt;
		res.no_retransmit     = nr_nxt;
		res.hash_len          = hs_nxt;
		res.hop_count         = hops_nxt;
		res.path_byte_count   = pb_nxt;
		res.payload_length    = pc_nxt;
		if (!last_byte) begin
			res.end_status = mpd_pkg::END_NONE;
		end else if (sec_nxt == mpd_pkg::SEC_PAY) begin
			res.end_status = mpd_pkg::END_DONE;
		end else begin
			res.end_status = mpd_pkg::END_TRUNC;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= mpd_pkg::SEC_HDR;
			cnt_q  <= 8'd0;
			rt_q   <= 2'd0;
			pt_q   <= 4'd0;
			ver_q  <= 2'd0;
			nr_q   <= 1'b0;
			hs_q   <= 3'd1;
			hops_q <= 6'd0;
			pb_q   <= 8'd0;
			pc_q   <= 8'd0;
		end else if (adv) begin
			sec_q  <= sec_upd;
			cnt_q  <= cnt_upd;
			rt_q   <= rt_nxt;
			pt_q   <= pt_nxt;
			ver_q  <= ver_nxt;
			nr_q   <= nr_nxt;
			hs_q   <= hs_nxt;
			hops_q <= hops_nxt;
			pb_q   <= pb_nxt;
			pc_q   <= pc_nxt;
		end
	end

`ifndef SYNTHESIS
	a_last_to_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_byte |=> sec_q == mpd_pkg::SEC_HDR && cnt_q == 8'd0)
		else $error("last byte did not return to header");
	a_hdr_clears_pay: assert property (@(posedge clk) disable iff (!arst_n)
		adv && sec_q == mpd_pkg::SEC_HDR |=> pc_q == 8'd0 && pb_q == 8'd0)
		else $error("header did not clear payload and path counts");
	a_path_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q == mpd_pkg::SEC_PATH |-> pb_q != 8'd0)
		else $error("path section with zero path bytes");
	a_xpt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sec_q == mpd_pkg::SEC_XPT |-> {1'b0, cnt_q} < 9'(TRANSPORT_CODE_BYTES))
		else $error("transport code count overran");
`endif

endmodule

### rtl/mesh_packet_deframer.sv
// Top level of the mesh packet deframer: input stage, parser, result stage.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata = data_byte, s_tlast = last_byte
//  m_*       out  m_tvalid/m_tready  m_tdata = result fields, m_tuser = section, end_status
//  APB       in   psel/penable       transport_route_mask at byte address 0
//
// One byte per cycle sustained while m_tready stays high; a byte is registered in the
// input stage, then its result in the result stage, from which its output transfer is made.
// The section decode sits between the input stage and the result register.
// Reset returns to the header section with mask 9 and clears both stages.
// A stall on m_tready backs up through the result stage; the input stage keeps
// accepting while the result stage can drain or is empty.
`timescale 1ns / 1ps
module mesh_packet_deframer #(
	parameter int MAX_PATH_BYTES       = 64,
	parameter int TRANSPORT_CODE_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] byte_value, [15:8] offset_in_section, [17:16] route_code,
	// [21:18] pay_kind, [23:22] version, [24] no_retransmit,
	// [27:25] hash_len, [33:28] hop_count, [41:34] path_byte_count,
	// [49:42] payload_length, [55:50] zero
	output logic [55:0] m_tdata,
	output logic [4:0]  m_tuser,   // [2:0] section, [4:3] end_status
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic          v_s1, last_s1, v_s2, adv_s1;
	logic [7:0]    data_s1;
	logic [3:0]    route_mask;
	mpd_pkg::res_t res, res_s2;

	assign adv_s1   = v_s1 && (!v_s2 || m_tready);
	assign s_tready = !v_s1 || adv_s1;
	assign m_tvalid = v_s2;
	assign m_tdata  = {6'd0, res_s2.payload_length, res_s2.path_byte_count, res_s2.hop_count,
		res_s2.hash_len, res_s2.no_retransmit, res_s2.version, res_s2.pay_kind,
		res_s2.route_code, res_s2.offset_in_section, res_s2.byte_value};
	assign m_tuser  = {res_s2.end_status, res_s2.section};

	mpd_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.route_mask (route_mask)
	);

	mpd_parse #(
		.MAX_PATH_BYTES       (MAX_PATH_BYTES),
		.TRANSPORT_CODE_BYTES (TRANSPORT_CODE_BYTES)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv_s1),
		.data_byte  (data_s1),
		.last_byte  (last_s1),
		.route_mask (route_mask),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				v_s1 <= 1'b1;
			end else if (adv_s1) begin
				v_s1 <= 1'b0;
			end
			if (adv_s1) begin
				v_s2 <= 1'b1;
			end else if (m_tready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

endmodule
